// ===== hdl/gbpf_pkg.sv =====
`default_nettype none
package gbpf_pkg;

    typedef enum logic [1:0] {
        CMD_DRAW = 2'd0,
        CMD_LOAD = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_WHITE        = 2'd0,
        MODE_BLACK        = 2'd1,
        MODE_WHITE_ON_BLK = 2'd2,
        MODE_BLACK_ON_WHT = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FONT_RD,
        ST_FB_RD,
        ST_FB_WR,
        ST_RD_WAIT,
        ST_DONE
    } back_state_t;

    localparam int unsigned GLYPH_COUNT = 95;
    localparam int unsigned CODE_FIRST  = 32;
    localparam int unsigned CODE_LAST   = 126;
    localparam int unsigned CODE_QMARK  = 63;

    // Map a character code to its glyph index.
    function automatic logic [6:0] glyph_index(input logic [7:0] code);
        logic [6:0] g;
        begin
            if (code < 8'(CODE_FIRST)) begin
                g = 7'd0;
            end else if (code > 8'(CODE_LAST)) begin
                g = 7'(CODE_QMARK - CODE_FIRST);
            end else begin
                g = 7'(code - 8'(CODE_FIRST));
            end
            return g;
        end
    endfunction

    // One framebuffer byte after fill and glyph pixels are applied.
    function automatic logic [7:0] paint(input logic [7:0] v_in, input logic [7:0] mask,
                                         input logic [7:0] bits, input mode_t mode);
        logic [7:0] v;
        begin
            v = v_in;
            if (mode == MODE_WHITE_ON_BLK) begin
                v = v | mask;
            end else if (mode == MODE_BLACK_ON_WHT) begin
                v = v & ~mask;
            end
            if (mode == MODE_BLACK || mode == MODE_BLACK_ON_WHT) begin
                v = v | bits;
            end else begin
                v = v & ~bits;
            end
            return v;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/gbpf_cmd_if.sv =====
`default_nettype none
interface gbpf_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic signed [7:0] x_pos;
    logic signed [7:0] y_pos;
    logic [7:0] char_code;
    logic [1:0] color_mode;
    logic [9:0] font_address;
    logic [7:0] font_byte;
    logic [9:0] fb_address;

    modport source (output valid, cmd, x_pos, y_pos, char_code, color_mode,
                    font_address, font_byte, fb_address, input ready);
    modport sink (input valid, cmd, x_pos, y_pos, char_code, color_mode,
                  font_address, font_byte, fb_address, output ready);
endinterface
`default_nettype wire

// ===== hdl/gbpf_rsp_if.sv =====
`default_nettype none
interface gbpf_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       drawn;

    modport source (output valid, read_data, drawn, input ready);
    modport sink (input valid, read_data, drawn, output ready);
endinterface
`default_nettype wire

// ===== hdl/gbpf_job_if.sv =====
`default_nettype none
// Classified job passed from the front end to the back end through the queue.
interface gbpf_job_if #(
    parameter int unsigned XW = 8,
    parameter int unsigned PW = 5,
    parameter int unsigned AW = 10,
    parameter int unsigned FW = 10
);
    logic          valid;
    logic          ready;
    logic [1:0]    cmd;
    logic          draw_ok;
    logic [XW-1:0] x;
    logic [PW-1:0] page;
    logic [2:0]    shift;
    logic          has_lower;
    logic [6:0]    glyph;
    logic [1:0]    mode;
    logic [FW-1:0] font_addr;
    logic          font_ok;
    logic [7:0]    font_byte;
    logic [AW-1:0] fb_addr;
    logic          fb_ok;

    modport source (output valid, cmd, draw_ok, x, page, shift, has_lower, glyph, mode,
                    font_addr, font_ok, font_byte, fb_addr, fb_ok, input ready);
    modport sink (input valid, cmd, draw_ok, x, page, shift, has_lower, glyph, mode,
                  font_addr, font_ok, font_byte, fb_addr, fb_ok, output ready);
endinterface
`default_nettype wire

// ===== hdl/gbpf_front.sv =====
`default_nettype none
// Front end: checks clipping and ranges and hands a classified job to a
// two-entry queue.
module gbpf_front #(
    parameter int unsigned SCREEN_WIDTH  = 96,
    parameter int unsigned SCREEN_HEIGHT = 64,
    parameter int unsigned GLYPH_WIDTH   = 6,
    parameter int unsigned XW = 8,
    parameter int unsigned PW = 5,
    parameter int unsigned AW = 10,
    parameter int unsigned FW = 10
) (
    input  wire logic clk,
    input  wire logic rst_n,
    gbpf_cmd_if.sink  cmd_in,
    gbpf_job_if.source job_out
);
    localparam int unsigned PAGE_ROWS   = (SCREEN_HEIGHT + 7) / 8;
    localparam int unsigned FRAME_BYTES = SCREEN_WIDTH * PAGE_ROWS;
    localparam int unsigned FONT_BYTES  = gbpf_pkg::GLYPH_COUNT * GLYPH_WIDTH;
    localparam int unsigned QW = 2 + 1 + XW + PW + 3 + 1 + 7 + 2 + FW + 1 + 8 + AW + 1;

    logic [QW-1:0] q_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic [QW-1:0] entry;
    logic          push, pop;

    logic signed [9:0] xs, ys;
    logic          clip_ok;
    logic [7:0]    y_u;
    logic [PW-1:0] page;
    logic          lower;

    always_comb
    begin
        xs      = 10'(cmd_in.x_pos);
        ys      = 10'(cmd_in.y_pos);
        y_u     = cmd_in.y_pos;
        page    = PW'(y_u >> 3);
        clip_ok = (ys >= 0) && (ys < 10'(SCREEN_HEIGHT)) && (xs >= 0)
                  && (xs + 10'(GLYPH_WIDTH) - 10'sd1 < 10'(SCREEN_WIDTH));
        lower   = (y_u[2:0] != 3'd0) && (9'(page) + 9'd1 < 9'(PAGE_ROWS));
        entry = {cmd_in.cmd, clip_ok, XW'(cmd_in.x_pos), page, y_u[2:0], lower,
                 gbpf_pkg::glyph_index(cmd_in.char_code), cmd_in.color_mode,
                 FW'(cmd_in.font_address),
                 (32'(cmd_in.font_address) < FONT_BYTES), cmd_in.font_byte,
                 AW'(cmd_in.fb_address),
                 (32'(cmd_in.fb_address) < FRAME_BYTES)};
    end

    assign cmd_in.ready  = (cnt_reg != 2'd2);
    assign push          = cmd_in.valid && cmd_in.ready;
    assign pop           = job_out.valid && job_out.ready;
    assign job_out.valid = (cnt_reg != 2'd0);

    logic [QW-1:0] head;
    assign head = q_reg[rd_ptr_reg];
    assign {job_out.cmd, job_out.draw_ok, job_out.x, job_out.page, job_out.shift,
            job_out.has_lower, job_out.glyph, job_out.mode, job_out.font_addr,
            job_out.font_ok, job_out.font_byte, job_out.fb_addr, job_out.fb_ok} = head;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== hdl/gbpf_back.sv =====
`default_nettype none
// Back end: executes one job at a time against the font and frame memories.
module gbpf_back #(
    parameter int unsigned SCREEN_WIDTH  = 96,
    parameter int unsigned SCREEN_HEIGHT = 64,
    parameter int unsigned GLYPH_WIDTH   = 6,
    parameter int unsigned XW = 8,
    parameter int unsigned PW = 5,
    parameter int unsigned AW = 10,
    parameter int unsigned FW = 10
) (
    input  wire logic clk,
    input  wire logic rst_n,
    gbpf_job_if.sink  job_in,
    gbpf_rsp_if.source rsp_out
);
    localparam int unsigned PAGE_ROWS   = (SCREEN_HEIGHT + 7) / 8;
    localparam int unsigned FRAME_BYTES = SCREEN_WIDTH * PAGE_ROWS;
    localparam int unsigned FONT_BYTES  = gbpf_pkg::GLYPH_COUNT * GLYPH_WIDTH;
    localparam int unsigned CW = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;

    logic [7:0] font_mem [FONT_BYTES];
    logic [7:0] frame_mem [FRAME_BYTES];

    gbpf_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          clr_busy_reg, clr_busy_next;
    logic [CW-1:0] col_reg, col_next;
    logic          half_reg, half_next;
    logic [7:0]    col_byte_reg;
    logic [7:0]    fb_q_reg;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_data_reg, out_data_next;
    logic          out_drawn_reg, out_drawn_next;

    logic          font_re, fb_re, fb_we;
    logic [FW-1:0] font_ra;
    logic [AW-1:0] fb_a;
    logic [7:0]    fb_wd;
    logic [7:0]    mask, bits;
    logic [AW+1:0] base;

    always_comb
    begin
        font_ra = FW'(job_in.glyph * (FW+4)'(GLYPH_WIDTH) + (FW+4)'(col_reg));
        base    = (AW+2)'((AW+2)'(job_in.page) + (AW+2)'(half_reg))
                  * (AW+2)'(SCREEN_WIDTH) + (AW+2)'(job_in.x) + (AW+2)'(col_reg);
        if (!half_reg)
        begin
            mask = 8'hFF << job_in.shift;
            bits = col_byte_reg << job_in.shift;
        end
        else
        begin
            mask = 8'hFF >> (4'd8 - 4'(job_in.shift));
            bits = col_byte_reg >> (4'd8 - 4'(job_in.shift));
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        clr_busy_next  = clr_busy_reg;
        col_next       = col_reg;
        half_next      = half_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_drawn_next = out_drawn_reg;
        font_re = 1'b0;
        fb_re   = 1'b0;
        fb_we   = 1'b0;
        fb_a    = AW'(base);
        fb_wd   = gbpf_pkg::paint(fb_q_reg, mask, bits, gbpf_pkg::mode_t'(job_in.mode));
        job_in.ready = 1'b0;
        if (rsp_out.valid && rsp_out.ready) out_valid_next = 1'b0;
        unique case (state_reg)
            gbpf_pkg::ST_IDLE:
            begin
                if (clr_busy_reg)
                begin
                    fb_we = 1'b1;
                    fb_a  = clr_reg;
                    fb_wd = 8'h00;
                    clr_next = clr_reg + AW'(1);
                    if (32'(clr_reg) == FRAME_BYTES - 1) clr_busy_next = 1'b0;
                end
                else if (job_in.valid && !out_valid_reg)
                begin
                    col_next  = '0;
                    half_next = 1'b0;
                    if (job_in.cmd == gbpf_pkg::CMD_DRAW && job_in.draw_ok)
                        state_next = gbpf_pkg::ST_FONT_RD;
                    else if (job_in.cmd == gbpf_pkg::CMD_READ && job_in.fb_ok)
                    begin
                        fb_re = 1'b1;
                        fb_a  = job_in.fb_addr;
                        state_next = gbpf_pkg::ST_RD_WAIT;
                    end
                    else
                        state_next = gbpf_pkg::ST_DONE;
                end
            end
            gbpf_pkg::ST_FONT_RD:
            begin
                font_re    = 1'b1;
                state_next = gbpf_pkg::ST_FB_RD;
            end
            gbpf_pkg::ST_FB_RD:
            begin
                fb_re      = 1'b1;
                state_next = gbpf_pkg::ST_FB_WR;
            end
            gbpf_pkg::ST_FB_WR:
            begin
                fb_we = 1'b1;
                if (!half_reg && job_in.has_lower)
                begin
                    half_next  = 1'b1;
                    state_next = gbpf_pkg::ST_FB_RD;
                end
                else if (32'(col_reg) == GLYPH_WIDTH - 1)
                    state_next = gbpf_pkg::ST_DONE;
                else
                begin
                    half_next  = 1'b0;
                    col_next   = col_reg + CW'(1);
                    state_next = gbpf_pkg::ST_FONT_RD;
                end
            end
            gbpf_pkg::ST_RD_WAIT:
            begin
                job_in.ready   = 1'b1;
                out_valid_next = 1'b1;
                out_data_next  = fb_q_reg;
                out_drawn_next = 1'b0;
                state_next     = gbpf_pkg::ST_IDLE;
            end
            gbpf_pkg::ST_DONE:
            begin
                job_in.ready   = 1'b1;
                out_valid_next = 1'b1;
                out_data_next  = 8'h00;
                out_drawn_next = (job_in.cmd == gbpf_pkg::CMD_DRAW) && job_in.draw_ok;
                state_next     = gbpf_pkg::ST_IDLE;
            end
            default: state_next = gbpf_pkg::ST_IDLE;
        endcase
    end

    // Font load happens as the job retires from the DONE state.
    always_ff @(posedge clk)
    begin
        if (state_reg == gbpf_pkg::ST_DONE && job_in.cmd == gbpf_pkg::CMD_LOAD
            && job_in.font_ok)
        begin
            font_mem[job_in.font_addr] <= job_in.font_byte;
        end
        if (font_re)
        begin
            col_byte_reg <= font_mem[font_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fb_we)
        begin
            frame_mem[fb_a] <= fb_wd;
        end
        if (fb_re)
        begin
            fb_q_reg <= frame_mem[fb_a];
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_drawn_reg <= out_drawn_next;
        col_reg       <= col_next;
        half_reg      <= half_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gbpf_pkg::ST_IDLE;
            clr_reg       <= '0;
            clr_busy_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            clr_busy_reg  <= clr_busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_out.valid     = out_valid_reg;
    assign rsp_out.read_data = out_data_reg;
    assign rsp_out.drawn     = out_drawn_reg;
endmodule
`default_nettype wire

// ===== hdl/glyph_blit_page_framebuffer.sv =====
`default_nettype none
// Glyph blitter for a page-organized monochrome framebuffer (8 vertical
// pixels per byte). Commands arrive as transactions on cmd_in: draw a glyph,
// load one font column byte, or read one framebuffer byte. Each command yields
// exactly one response transaction on rsp_out carrying read_data and drawn.
// A front end classifies commands (clipping, glyph mapping, range checks) and
// queues up to two of them; a back end executes one at a time through a
// single port on each memory. For each glyph column a draw reads the font
// byte, then reads and writes the framebuffer byte, and repeats the read and
// write for the lower byte when the glyph spans two pages. A new command
// starts only once the previous response has left the output register.
// After reset the back end clears the framebuffer, one byte per cycle, over all
// SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 8) bytes (768 by default);
// commands are queued meanwhile but not executed. The font store is not
// cleared and must be loaded before drawing. While the receiver stalls, the
// response is held in its output register and the queue keeps accepting
// commands until it is full.
module glyph_blit_page_framebuffer #(
    parameter int unsigned SCREEN_WIDTH  = 96,
    parameter int unsigned SCREEN_HEIGHT = 64,
    parameter int unsigned GLYPH_WIDTH   = 6
) (
    input  wire logic clk,
    input  wire logic rst_n,
    gbpf_cmd_if.sink  cmd_in,
    gbpf_rsp_if.source rsp_out
);
    localparam int unsigned PAGE_ROWS   = (SCREEN_HEIGHT + 7) / 8;
    localparam int unsigned FRAME_BYTES = SCREEN_WIDTH * PAGE_ROWS;
    localparam int unsigned FONT_BYTES  = gbpf_pkg::GLYPH_COUNT * GLYPH_WIDTH;
    localparam int unsigned XW = 8;
    localparam int unsigned PW = 5;
    localparam int unsigned AW = $clog2(FRAME_BYTES);
    localparam int unsigned FW = $clog2(FONT_BYTES);

    // Classified jobs between the two halves.
    gbpf_job_if #(.XW(XW), .PW(PW), .AW(AW), .FW(FW)) job ();

    gbpf_front #(
        .SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT),
        .GLYPH_WIDTH(GLYPH_WIDTH), .XW(XW), .PW(PW), .AW(AW), .FW(FW)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .cmd_in(cmd_in), .job_out(job)
    );

    gbpf_back #(
        .SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT),
        .GLYPH_WIDTH(GLYPH_WIDTH), .XW(XW), .PW(PW), .AW(AW), .FW(FW)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .job_in(job), .rsp_out(rsp_out)
    );
endmodule
`default_nettype wire

// ===== bench/gbpf_bench_if.sv =====
`timescale 1ns / 100ps
`default_nettype none
// Bench-side view of the block's two channels. The bench instantiates the
// block's own interface types directly; this file only carries the
// transaction records shared by the bench processes.
package gbpf_bench_pkg;

    typedef struct packed {
        gbpf_pkg::cmd_t  cmd;
        logic [7:0]      x_pos;
        logic [7:0]      y_pos;
        logic [7:0]      char_code;
        gbpf_pkg::mode_t color_mode;
        logic [9:0]      font_address;
        logic [7:0]      font_byte;
        logic [9:0]      fb_address;
    } blit_cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       drawn;
    } blit_rsp_t;
endpackage
`default_nettype wire

// ===== bench/glyph_blit_page_framebuffer_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none

// Shadow of the framebuffer and font memory. Each accepted command updates
// the shadow and queues the response the block must return for it.
class blit_scoreboard;
    localparam int WIDTH = 96;
    localparam int HEIGHT = 64;
    localparam int GW = 6;
    localparam int PAGES = (HEIGHT + 7) / 8;
    localparam int FB_BYTES = WIDTH * PAGES;
    localparam int FONT_BYTES = 95 * GW;

    logic [7:0] frame_mem[FB_BYTES];
    logic [7:0] font_mem[FONT_BYTES];
    gbpf_bench_pkg::blit_rsp_t pending_rsp[$];
    int errors;

    function new();
        foreach (frame_mem[i]) frame_mem[i] = 8'h00;
        foreach (font_mem[i]) font_mem[i] = 8'h00;
        errors = 0;
    endfunction

    function void apply_byte(int addr, logic [7:0] mask, logic [7:0] bits,
                             gbpf_pkg::mode_t m);
        logic [7:0] v;
        if (addr >= FB_BYTES) return;
        v = frame_mem[addr];
        if (m == gbpf_pkg::MODE_WHITE_ON_BLK) v = v | mask;
        else if (m == gbpf_pkg::MODE_BLACK_ON_WHT) v = v & ~mask;
        if (m == gbpf_pkg::MODE_BLACK || m == gbpf_pkg::MODE_BLACK_ON_WHT) v = v | bits;
        else v = v & ~bits;
        frame_mem[addr] = v;
    endfunction

    function void note_command(gbpf_bench_pkg::blit_cmd_t c);
        gbpf_bench_pkg::blit_rsp_t r;
        r = '0;
        case (c.cmd)
            gbpf_pkg::CMD_DRAW: r.drawn = draw_with_fill(c);
            gbpf_pkg::CMD_LOAD:
                if (c.font_address < FONT_BYTES) font_mem[c.font_address] = c.font_byte;
            gbpf_pkg::CMD_READ:
                if (c.fb_address < FB_BYTES) r.read_data = frame_mem[c.fb_address];
            default: ;
        endcase
        pending_rsp.push_back(r);
    endfunction

    // Full draw with the proper fill masks for both byte rows.
    function bit draw_with_fill(gbpf_bench_pkg::blit_cmd_t c);
        int x, y, page, shift, g;
        logic [15:0] col, fill;
        x = $signed(c.x_pos);
        y = $signed(c.y_pos);
        if (y < 0 || y >= HEIGHT || x < 0 || x + GW - 1 >= WIDTH) return 0;
        page = y / 8;
        shift = y % 8;
        if (c.char_code < 32) g = 0;
        else if (c.char_code > 126) g = 31;
        else g = c.char_code - 32;
        fill = 16'h00FF << shift;
        for (int i = 0; i < GW; i++) begin
            col = {8'h00, font_mem[g * GW + i]} << shift;
            apply_byte(page * WIDTH + x + i, fill[7:0], col[7:0], c.color_mode);
            if (shift != 0 && page + 1 < PAGES)
                apply_byte((page + 1) * WIDTH + x + i, fill[15:8], col[15:8], c.color_mode);
        end
        return 1;
    endfunction

    function void check_response(gbpf_bench_pkg::blit_rsp_t got);
        gbpf_bench_pkg::blit_rsp_t want;
        if (pending_rsp.size() == 0) begin
            $display("%0t: response with none expected: data %h drawn %b",
                     $time, got.read_data, got.drawn);
            errors++;
            return;
        end
        want = pending_rsp.pop_front();
        if (got.read_data !== want.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                     got.read_data);
            errors++;
        end
        if (got.drawn !== want.drawn) begin
            $display("%0t: drawn expected %b actual %b", $time, want.drawn, got.drawn);
            errors++;
        end
    endfunction
endclass

module glyph_blit_page_framebuffer_tb;
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    gbpf_cmd_if cmd_bus();
    gbpf_rsp_if rsp_bus();

    glyph_blit_page_framebuffer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_in (cmd_bus.sink),
        .rsp_out(rsp_bus.source)
    );

    always #1 clk = ~clk;

    blit_scoreboard board = new();

    // Set while the sink is forced to hold off for a long stretch; the
    // response process counts those cycles itself.
    bit long_stall_req = 1'b0;
    bit stimulus_done = 1'b0;

    // Glyph indices whose six columns have been loaded. Draws only use these
    // so that no unwritten font entry is ever read.
    bit glyph_loaded[95];

    initial begin
        cmd_bus.valid <= 1'b0;
        cmd_bus.cmd <= gbpf_pkg::CMD_NONE;
        cmd_bus.x_pos <= '0;
        cmd_bus.y_pos <= '0;
        cmd_bus.char_code <= '0;
        cmd_bus.color_mode <= '0;
        cmd_bus.font_address <= '0;
        cmd_bus.font_byte <= '0;
        cmd_bus.fb_address <= '0;
        rsp_bus.ready <= 1'b0;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // Offer one command and hold it until the block accepts the transaction.
    // The shadow model is updated at the same edge as the acceptance. Valid
    // stays high afterwards so that the next command can follow at once; it
    // drops only for an idle gap or when the caller lowers it.
    task automatic send_command(gbpf_bench_pkg::blit_cmd_t c, bit idle_gaps);
        int gap;
        gap = idle_gaps ? gap_length() : 0;
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.cmd <= c.cmd;
        cmd_bus.x_pos <= c.x_pos;
        cmd_bus.y_pos <= c.y_pos;
        cmd_bus.char_code <= c.char_code;
        cmd_bus.color_mode <= c.color_mode;
        cmd_bus.font_address <= c.font_address;
        cmd_bus.font_byte <= c.font_byte;
        cmd_bus.fb_address <= c.fb_address;
        @(posedge clk);
        while (!cmd_bus.ready) @(posedge clk);
        board.note_command(c);
    endtask

    // A random glyph from those already loaded, mapped back to a code that
    // selects it, occasionally through the unprintable and high-code paths.
    function automatic logic [7:0] pick_code();
        int g;
        do g = $urandom_range(0, 94); while (!glyph_loaded[g]);
        if (g == 0 && $urandom_range(0, 1)) return 8'($urandom_range(0, 31));
        if (g == 31 && $urandom_range(0, 1)) return 8'($urandom_range(127, 255));
        return 8'(g + 32);
    endfunction

    function automatic gbpf_bench_pkg::blit_cmd_t make_draw(int x, int y, logic [7:0] code,
                                                           int m);
        gbpf_bench_pkg::blit_cmd_t c;
        c = '0;
        c.cmd = gbpf_pkg::CMD_DRAW;
        c.x_pos = 8'(x);
        c.y_pos = 8'(y);
        c.char_code = code;
        c.color_mode = gbpf_pkg::mode_t'(2'(m));
        c.font_address = 10'($urandom);
        c.font_byte = 8'($urandom);
        c.fb_address = 10'($urandom);
        return c;
    endfunction

    function automatic gbpf_bench_pkg::blit_cmd_t make_load(int addr, logic [7:0] data);
        gbpf_bench_pkg::blit_cmd_t c;
        c = make_draw($urandom, $urandom, 8'($urandom), $urandom_range(0, 3));
        c.cmd = gbpf_pkg::CMD_LOAD;
        c.font_address = 10'(addr);
        c.font_byte = data;
        return c;
    endfunction

    function automatic gbpf_bench_pkg::blit_cmd_t make_read(int addr);
        gbpf_bench_pkg::blit_cmd_t c;
        c = make_draw($urandom, $urandom, 8'($urandom), $urandom_range(0, 3));
        c.cmd = gbpf_pkg::CMD_READ;
        c.fb_address = 10'(addr);
        return c;
    endfunction

    task automatic load_glyph(int g, bit idle_gaps);
        for (int i = 0; i < 6; i++)
            send_command(make_load(g * 6 + i, 8'($urandom)), idle_gaps);
        glyph_loaded[g] = 1'b1;
    endtask

    // Random command mix: mostly draws and reads so the framebuffer sees
    // plenty of traffic, with loads, unused commands and out-of-range cases.
    function automatic gbpf_bench_pkg::blit_cmd_t random_command();
        int sel, x, y;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            if ($urandom_range(0, 9) == 0) begin
                x = $signed(8'($urandom));
                y = $signed(8'($urandom));
            end else begin
                x = $urandom_range(0, 90);
                y = $urandom_range(0, 63);
            end
            return make_draw(x, y, pick_code(), $urandom_range(0, 3));
        end else if (sel < 80) begin
            if ($urandom_range(0, 19) == 0) return make_read($urandom_range(768, 1023));
            return make_read($urandom_range(0, 767));
        end else if (sel < 95) begin
            if ($urandom_range(0, 9) == 0)
                return make_load($urandom_range(570, 1023), 8'($urandom));
            return make_load($urandom_range(0, 569), 8'($urandom));
        end else begin
            gbpf_bench_pkg::blit_cmd_t c;
            c = make_read($urandom);
            c.cmd = gbpf_pkg::CMD_NONE;
            return c;
        end
    endfunction

    // Response side: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        gbpf_bench_pkg::blit_rsp_t got;
        wait (rst_n);
        forever begin
            if (long_stall_req) begin
                rsp_bus.ready <= 1'b0;
                repeat (400) @(posedge clk);
                long_stall_req = 1'b0;
            end
            stall = gap_length();
            if (stall > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            @(posedge clk);
            if (rsp_bus.valid && rsp_bus.ready) begin
                got.read_data = rsp_bus.read_data;
                got.drawn = rsp_bus.drawn;
                board.check_response(got);
            end
        end
    end

    // Stimulus.
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole font first, with no gaps, so any glyph can be drawn.
        // This also queues commands while the framebuffer clear runs.
        for (int g = 0; g < 95; g++) load_glyph(g, 1'b0);
        // Extreme font bytes on the space and '?' glyphs, then loads at the last font address and beyond it.
        send_command(make_load(0, 8'hFF), 1'b0);
        send_command(make_load(31 * 6 + 5, 8'h00), 1'b0);
        send_command(make_load(569, 8'hA5), 1'b0);
        send_command(make_load(570, 8'h5A), 1'b0);
        send_command(make_load(1023, 8'hFF), 1'b0);

        // Directed draws: every mode, corners, clipped cells, split rows and the bottom row, plus
        // unprintable and high codes; then reads in and out of range and an unused command.
        send_command(make_draw(0, 0, 8'h41, 0), 1'b0);
        send_command(make_draw(90, 0, 8'h7E, 1), 1'b0);
        send_command(make_draw(91, 0, 8'h41, 2), 1'b0);
        send_command(make_draw(-1, 8, 8'h41, 2), 1'b0);
        send_command(make_draw(-128, -128, 8'h41, 3), 1'b0);
        send_command(make_draw(127, 127, 8'h41, 3), 1'b0);
        send_command(make_draw(0, -1, 8'h41, 1), 1'b0);
        send_command(make_draw(0, 64, 8'h41, 1), 1'b0);
        send_command(make_draw(10, 3, 8'h00, 2), 1'b0);
        send_command(make_draw(20, 60, 8'hFF, 3), 1'b0);
        send_command(make_draw(30, 63, 8'h80, 2), 1'b0);
        send_command(make_draw(40, 12, 8'h1F, 3), 1'b0);
        send_command(make_draw(50, 7, 8'h20, 1), 1'b0);
        send_command(make_read(0), 1'b0);
        send_command(make_read(90 + 96), 1'b0);
        send_command(make_read(767), 1'b0);
        send_command(make_read(768), 1'b0);
        send_command(make_read(1023), 1'b0);
        begin
            gbpf_bench_pkg::blit_cmd_t c;
            c = make_read(5);
            c.cmd = gbpf_pkg::CMD_NONE;
            send_command(c, 1'b0);
        end

        // Long hold-off on the response side while commands keep coming, so
        // the queue fills and the block stalls its input.
        long_stall_req = 1'b1;
        for (int n = 0; n < 20; n++) send_command(random_command(), 1'b0);

        // Pause until every expected response is back.
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_rsp.size() != 0) @(posedge clk);

        for (int n = 0; n < 480; n++) send_command(random_command(), 1'b1);
        cmd_bus.valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // End of run: drain, allow the block's latency, then report.
    initial begin
        wait (stimulus_done);
        while (board.pending_rsp.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.errors == 0 && board.pending_rsp.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: about 1100 commands with the longest gaps and stalls, plus the
    // framebuffer clear, stay far below this.
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
